FILE: sv/asmh_pkg.sv
// Package for the height-grid sampler: payload structs, sequencer states,
// neighbor tap codes and fixed sizes. No dependencies.
package asmh_pkg;

    localparam int MAX_ORDER = 63;
    localparam int GRID_SIDE = MAX_ORDER + 1;
    localparam int POS_W     = 6;
    localparam int ADDR_W    = 2 * POS_W;
    localparam int HEIGHT_W  = 7;
    localparam int GAP_W     = 18;

    localparam logic [POS_W-1:0] ORDER_RESET = 6'd8;

    typedef struct packed {
        logic start_over;
        logic coin;
    } t_in;

    typedef struct packed {
        logic [POS_W-1:0]    site_row;
        logic [POS_W-1:0]    site_col;
        logic [HEIGHT_W-1:0] lower_value;
        logic [HEIGHT_W-1:0] upper_value;
        logic                sweep_done;
        logic [GAP_W-1:0]    volume_gap;
        logic                coalesced;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_CHECK,
        ST_READ,
        ST_UPDATE,
        ST_ADV,
        ST_EMIT
    } t_state;

    // Order in which the site's neighborhood is fetched from the grids.
    typedef enum logic [2:0] {
        TAP_UP,
        TAP_RT,
        TAP_DN,
        TAP_LF,
        TAP_CTR,
        TAP_LAST
    } t_tap;

    // Strobes from the sequencer to the neighborhood unit, one per read beat.
    typedef struct packed {
        logic first;
        logic cmp;
        logic ctr;
    } t_tap_ctl;

endpackage

FILE: sv/asm_height_checkerboard_sampler_unit.sv
// Top level of the height-grid sampler: sequencer, walk position, gap counter.
// Depends on asmh_pkg, asmh_grid and asmh_site_unit.
//
// Input channel (i_in_valid/o_in_ready, payload t_in) takes one beat per
// item; output channel (o_out_valid/i_out_ready, payload t_out) returns one
// beat per item. The order register is written through i_cfg_wr_en and
// i_cfg_wr_data; the user must do so only while the block is idle, which
// the block does not enforce. Grids then have side order+1. A coin item
// fetches the site's four neighbors and the site itself through the single
// read port of the grid memories, one address per cycle, then writes back
// and steps the walk position; when the column runs past the interior the
// walk steps to the next row, twice per move at order 2. With order below
// 2 a coin item reads nothing and returns a beat with sweep_done set. A
// start_over item writes the extremal heights one site per cycle.
// o_in_ready is high only while no item is in progress. A finished beat
// sits in the output register; a stalled receiver holds the block at its
// last step until the register frees up, while an earlier beat may still
// wait there during the next item's work.
// Reset restores order 8, the walk start and a zero gap. The grids are not
// cleared: a coin item before the first start_over reads undefined heights.
module asm_height_checkerboard_sampler_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  asmh_pkg::t_in                i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output asmh_pkg::t_out               o_out,
    input  logic                         i_cfg_wr_en,
    input  logic [asmh_pkg::POS_W-1:0]   i_cfg_wr_data
);
    import asmh_pkg::*;

    t_state             r_state, n_state;
    t_tap               r_tap, n_tap;
    logic [POS_W-1:0]   r_order;
    logic [POS_W-1:0]   r_walk_row, n_walk_row;
    logic [POS_W:0]     r_walk_col, n_walk_col;
    logic               r_walk_phase, n_walk_phase;
    logic [GAP_W-1:0]   r_gap, n_gap;
    logic               r_out_valid, n_out_valid;

    logic [POS_W-1:0]   r_fr, n_fr;
    logic [POS_W-1:0]   r_fc, n_fc;
    logic [GAP_W-1:0]   r_acc, n_acc;
    logic               r_coin, n_coin;
    t_out               r_res, n_res;
    t_out               r_out, n_out;

    logic [ADDR_W-1:0]   grid_addr;
    logic                grid_we;
    logic [HEIGHT_W-1:0] grid_wlo, grid_whi;
    logic [HEIGHT_W-1:0] grid_rlo, grid_rhi;
    t_tap_ctl            tap_ctl;
    logic [HEIGHT_W-1:0] lo_ctr, lo_new, hi_ctr, hi_new;

    logic [POS_W-1:0]    col6;
    logic [POS_W-1:0]    row_inc;
    logic [POS_W:0]      side;
    logic [POS_W:0]      rc_diff, rc_sum, hi_dist;
    logic [HEIGHT_W-1:0] fill_lo, fill_hi;
    logic                walk_bad;

    asmh_grid u_grid (
        .i_clk      (i_clk),
        .i_addr     (grid_addr),
        .i_we       (grid_we),
        .i_wdata_lo (grid_wlo),
        .i_wdata_hi (grid_whi),
        .o_rdata_lo (grid_rlo),
        .o_rdata_hi (grid_rhi)
    );

    asmh_site_unit u_site_lo (
        .i_clk     (i_clk),
        .i_ctl     (tap_ctl),
        .i_rd_data (grid_rlo),
        .i_coin    (r_coin),
        .o_ctr     (lo_ctr),
        .o_new     (lo_new)
    );

    asmh_site_unit u_site_hi (
        .i_clk     (i_clk),
        .i_ctl     (tap_ctl),
        .i_rd_data (grid_rhi),
        .i_coin    (r_coin),
        .o_ctr     (hi_ctr),
        .o_new     (hi_new)
    );

    // Extremal heights at the fill position: lower |r-c|+1, upper s-|s-r-c-1|.
    always_comb begin
        side    = {1'b0, r_order} + 7'd1;
        rc_diff = (r_fr > r_fc) ? {1'b0, r_fr - r_fc} : {1'b0, r_fc - r_fr};
        rc_sum  = {1'b0, r_fr} + {1'b0, r_fc} + 7'd1;
        hi_dist = (side > rc_sum) ? side - rc_sum : rc_sum - side;
        fill_lo = rc_diff + 7'd1;
        fill_hi = side - hi_dist;
    end

    assign col6    = r_walk_col[POS_W-1:0];
    assign row_inc = r_walk_row + 6'd1;
    assign walk_bad = (r_walk_row == '0) || (r_walk_row >= r_order) ||
                      (r_walk_col == '0) || (r_walk_col >= {1'b0, r_order}) ||
                      ((r_walk_row[0] ^ r_walk_col[0]) != r_walk_phase);

    always_comb begin
        n_state      = r_state;
        n_tap        = r_tap;
        n_walk_row   = r_walk_row;
        n_walk_col   = r_walk_col;
        n_walk_phase = r_walk_phase;
        n_gap        = r_gap;
        n_out_valid  = r_out_valid;
        n_fr         = r_fr;
        n_fc         = r_fc;
        n_acc        = r_acc;
        n_coin       = r_coin;
        n_res        = r_res;
        n_out        = r_out;
        grid_addr    = {r_walk_row, col6};
        grid_we      = 1'b0;
        grid_wlo     = lo_new;
        grid_whi     = hi_new;
        tap_ctl      = '0;
        o_in_ready   = (r_state == ST_IDLE);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_coin = i_in.coin;
                    if (i_in.start_over) begin
                        n_fr    = '0;
                        n_fc    = '0;
                        n_acc   = '0;
                        n_state = ST_FILL;
                    end else if (r_order < 6'd2) begin
                        n_res            = '0;
                        n_res.sweep_done = 1'b1;
                        n_state          = ST_EMIT;
                    end else begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_FILL: begin
                grid_addr = {r_fr, r_fc};
                grid_we   = 1'b1;
                grid_wlo  = fill_lo;
                grid_whi  = fill_hi;
                n_acc     = r_acc + {11'd0, fill_hi} - {11'd0, fill_lo};
                if (r_fc == r_order) begin
                    n_fc = '0;
                    if (r_fr == r_order) begin
                        n_gap             = n_acc;
                        n_walk_row        = 6'd1;
                        n_walk_col        = 7'd1;
                        n_walk_phase      = 1'b0;
                        n_res             = '0;
                        // Both extremal grids hold 1 at the corner.
                        n_res.lower_value = 7'd1;
                        n_res.upper_value = 7'd1;
                        n_state           = ST_EMIT;
                    end else begin
                        n_fr = r_fr + 6'd1;
                    end
                end else begin
                    n_fc = r_fc + 6'd1;
                end
            end
            ST_CHECK: begin
                // A changed order can leave the walk off the current grid.
                if (walk_bad) begin
                    n_walk_row   = 6'd1;
                    n_walk_col   = 7'd1;
                    n_walk_phase = 1'b0;
                end
                n_tap   = TAP_UP;
                n_state = ST_READ;
            end
            ST_READ: begin
                unique case (r_tap)
                    TAP_UP:  grid_addr = {r_walk_row - 6'd1, col6};
                    TAP_RT:  grid_addr = {r_walk_row, col6 + 6'd1};
                    TAP_DN:  grid_addr = {row_inc, col6};
                    TAP_LF:  grid_addr = {r_walk_row, col6 - 6'd1};
                    default: grid_addr = {r_walk_row, col6};
                endcase
                // Read data arrives in the cycle after its address, so each strobe acts on the previous tap's data.
                tap_ctl.first = (r_tap == TAP_RT);
                tap_ctl.cmp   = (r_tap == TAP_DN) || (r_tap == TAP_LF) ||
                                (r_tap == TAP_CTR);
                tap_ctl.ctr   = (r_tap == TAP_LAST);
                if (r_tap == TAP_LAST) begin
                    n_state = ST_UPDATE;
                end else begin
                    n_tap = t_tap'(r_tap + 3'd1);
                end
            end
            ST_UPDATE: begin
                grid_we           = 1'b1;
                n_gap             = r_gap + {11'd0, hi_new} - {11'd0, hi_ctr}
                                    + {11'd0, lo_ctr} - {11'd0, lo_new};
                n_res.site_row    = r_walk_row;
                n_res.site_col    = col6;
                n_res.lower_value = lo_new;
                n_res.upper_value = hi_new;
                n_res.sweep_done  = 1'b0;
                n_walk_col        = r_walk_col + 7'd2;
                n_state           = ST_ADV;
            end
            ST_ADV: begin
                // One row step per cycle until the column lands inside the interior.
                if (r_walk_col >= {1'b0, r_order}) begin
                    if (row_inc >= r_order) begin
                        n_walk_row   = 6'd1;
                        n_walk_phase = ~r_walk_phase;
                        if (r_walk_phase) begin
                            n_res.sweep_done = 1'b1;
                        end
                    end else begin
                        n_walk_row = row_inc;
                    end
                    n_walk_col = (n_walk_row[0] == n_walk_phase) ? 7'd2 : 7'd1;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out            = r_res;
                    n_out.volume_gap = r_gap;
                    n_out.coalesced  = (r_gap == '0);
                    n_out_valid      = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_tap        <= TAP_UP;
            r_order      <= ORDER_RESET;
            r_walk_row   <= 6'd1;
            r_walk_col   <= 7'd1;
            r_walk_phase <= 1'b0;
            r_gap        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_tap        <= n_tap;
            r_walk_row   <= n_walk_row;
            r_walk_col   <= n_walk_col;
            r_walk_phase <= n_walk_phase;
            r_gap        <= n_gap;
            r_out_valid  <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_order <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fr   <= n_fr;
        r_fc   <= n_fc;
        r_acc  <= n_acc;
        r_coin <= n_coin;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A result beat only appears out of the emit step.
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_EMIT))
        else $error("result beat raised outside the emit step");

    a_coalesced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.coalesced == (o_out.volume_gap == '0)))
        else $error("coalesced flag disagrees with the volume gap");

    // Neighbor fetches must stay on interior sites of the current grid.
    a_walk_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_walk_row != '0 && r_walk_row < r_order &&
                                  r_walk_col != '0 && r_walk_col < {1'b0, r_order}))
        else $error("walk position outside the interior during a read");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != ST_IDLE))
        else $error("sequencer idle right after taking a beat");

endmodule

FILE: sv/asmh_grid.sv
// Lower and upper height grids, one shared address, registered read data.
// Depends on asmh_pkg.
module asmh_grid (
    input  logic                           i_clk,
    input  logic [asmh_pkg::ADDR_W-1:0]    i_addr,
    input  logic                           i_we,
    input  logic [asmh_pkg::HEIGHT_W-1:0]  i_wdata_lo,
    input  logic [asmh_pkg::HEIGHT_W-1:0]  i_wdata_hi,
    output logic [asmh_pkg::HEIGHT_W-1:0]  o_rdata_lo,
    output logic [asmh_pkg::HEIGHT_W-1:0]  o_rdata_hi
);
    import asmh_pkg::*;

    logic [HEIGHT_W-1:0] r_mem_lo [GRID_SIDE*GRID_SIDE];
    logic [HEIGHT_W-1:0] r_mem_hi [GRID_SIDE*GRID_SIDE];
    logic [HEIGHT_W-1:0] r_rd_lo;
    logic [HEIGHT_W-1:0] r_rd_hi;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_lo[i_addr] <= i_wdata_lo;
            r_mem_hi[i_addr] <= i_wdata_hi;
        end
        r_rd_lo <= r_mem_lo[i_addr];
        r_rd_hi <= r_mem_hi[i_addr];
    end

    assign o_rdata_lo = r_rd_lo;
    assign o_rdata_hi = r_rd_hi;

endmodule

FILE: sv/asmh_site_unit.sv
// Neighborhood unit for one grid: a single comparator checks the fetched
// neighbors one beat at a time and forms the site's new height.
// Depends on asmh_pkg.
module asmh_site_unit (
    input  logic                           i_clk,
    input  asmh_pkg::t_tap_ctl             i_ctl,
    input  logic [asmh_pkg::HEIGHT_W-1:0]  i_rd_data,
    input  logic                           i_coin,
    output logic [asmh_pkg::HEIGHT_W-1:0]  o_ctr,
    output logic [asmh_pkg::HEIGHT_W-1:0]  o_new
);
    import asmh_pkg::*;

    logic [HEIGHT_W-1:0] r_up;
    logic [HEIGHT_W-1:0] r_ctr;
    logic                r_eq;

    always_ff @(posedge i_clk) begin
        if (i_ctl.first) begin
            r_up <= i_rd_data;
            r_eq <= 1'b1;
        end
        if (i_ctl.cmp) begin
            r_eq <= r_eq & (i_rd_data == r_up);
        end
        if (i_ctl.ctr) begin
            r_ctr <= i_rd_data;
        end
    end

    // Heat-bath move: only a site whose four neighbors agree may change.
    always_comb begin
        if (r_eq) begin
            o_new = i_coin ? r_up + 7'd1 : r_up - 7'd1;
        end else begin
            o_new = r_ctr;
        end
    end

    assign o_ctr = r_ctr;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for asm_height_checkerboard_sampler_unit: a predictor of the
// two height grids checks every output beat field by field. Depends on asmh_pkg and the RTL.
module tb_top;
    import asmh_pkg::*;

    logic              clk;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    t_in               in_beat     = '0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    t_out              out_beat;
    logic              cfg_wr_en   = 1'b0;
    logic [POS_W-1:0]  cfg_wr_data = '0;

    asm_height_checkerboard_sampler_unit u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_in          (in_beat),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out         (out_beat),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    // Mirror of the block's grids, walk position and gap.
    logic [HEIGHT_W-1:0] lower_grid [GRID_SIDE][GRID_SIDE];
    logic [HEIGHT_W-1:0] upper_grid [GRID_SIDE][GRID_SIDE];
    logic [POS_W-1:0]    grid_order  = ORDER_RESET;
    int                  walk_row    = 1;
    int                  walk_col    = 1;
    bit                  walk_phase  = 1'b0;
    logic [GAP_W-1:0]    gap_sum     = '0;
    int                  loaded_side = 0;

    t_out site_reports_due[$];
    int   error_count = 0;
    bit   idle_on     = 1'b1;
    int   stall_left  = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int roll;
        if (!idle_on) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // A site moves only when its four neighbors agree; it then lands one step off the up value.
    function automatic logic [HEIGHT_W-1:0] heat_bath(input logic [HEIGHT_W-1:0] cur, up, rt,
                                                      dn, lf, input logic coin);
        if (up == rt && rt == dn && dn == lf) begin
            return coin ? up + 7'd1 : up - 7'd1;
        end
        return cur;
    endfunction

    function automatic t_out predict_site_report(input t_in item);
        t_out                rep;
        int                  side, last, guard, r, c, lo, hi, total;
        logic [HEIGHT_W-1:0] old_lo, old_hi;
        rep  = '0;
        side = int'(grid_order) + 1;
        last = side - 2;
        if (item.start_over) begin
            total = 0;
            for (r = 0; r < side; r++) begin
                for (c = 0; c < side; c++) begin
                    lo = ((r > c) ? r - c : c - r) + 1;
                    hi = side - ((side > r + c + 1) ? side - (r + c + 1) : r + c + 1 - side);
                    lower_grid[r][c] = lo[HEIGHT_W-1:0];
                    upper_grid[r][c] = hi[HEIGHT_W-1:0];
                    total += int'(upper_grid[r][c]) - int'(lower_grid[r][c]);
                end
            end
            gap_sum    = total[GAP_W-1:0];
            walk_row   = 1;
            walk_col   = 1;
            walk_phase = 1'b0;
            rep.lower_value = lower_grid[0][0];
            rep.upper_value = upper_grid[0][0];
            if (side > loaded_side) begin
                loaded_side = side;
            end
        end else if (side < 3) begin
            rep.sweep_done = 1'b1;
        end else begin
            // A shrunken order can leave the position outside the interior or on the wrong color.
            if (walk_row < 1 || walk_row > last || walk_col < 1 || walk_col > last ||
                    ((walk_row + walk_col) % 2) != walk_phase) begin
                walk_row   = 1;
                walk_col   = 1;
                walk_phase = 1'b0;
            end
            rep.site_row = walk_row[POS_W-1:0];
            rep.site_col = walk_col[POS_W-1:0];
            old_lo = lower_grid[walk_row][walk_col];
            old_hi = upper_grid[walk_row][walk_col];
            lower_grid[walk_row][walk_col] = heat_bath(old_lo,
                lower_grid[walk_row-1][walk_col], lower_grid[walk_row][walk_col+1],
                lower_grid[walk_row+1][walk_col], lower_grid[walk_row][walk_col-1], item.coin);
            upper_grid[walk_row][walk_col] = heat_bath(old_hi,
                upper_grid[walk_row-1][walk_col], upper_grid[walk_row][walk_col+1],
                upper_grid[walk_row+1][walk_col], upper_grid[walk_row][walk_col-1], item.coin);
            rep.lower_value = lower_grid[walk_row][walk_col];
            rep.upper_value = upper_grid[walk_row][walk_col];
            gap_sum = gap_sum + rep.upper_value - old_hi + old_lo - rep.lower_value;

            walk_col += 2;
            guard = 0;
            while (walk_col > last && guard < 4 * GRID_SIDE) begin
                walk_row++;
                if (walk_row > last) begin
                    walk_row = 1;
                    if (walk_phase) begin
                        rep.sweep_done = 1'b1;
                    end
                    walk_phase = ~walk_phase;
                end
                walk_col = ((walk_row % 2) == walk_phase) ? 2 : 1;
                guard++;
            end
        end
        rep.volume_gap = gap_sum;
        rep.coalesced  = (gap_sum == '0);
        return rep;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got, want);
        error_count++;
        $display("%0t: %s mismatch, got %0d, want %0d", $time, what, got, want);
    endtask

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_beat(input logic start, input logic coin);
        t_in item;
        int  gap;
        item.start_over = start;
        item.coin       = coin;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        site_reports_due.push_back(predict_site_report(item));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (site_reports_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_order(input logic [POS_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        grid_order  = value;
    endtask

    always @(posedge clk) begin : check_beats
        t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (site_reports_due.size() == 0) begin
                report_mismatch("unexpected beat", 32'd1, 32'd0);
            end else begin
                want = site_reports_due.pop_front();
                if (out_beat.site_row !== want.site_row)
                    report_mismatch("site_row", 32'(out_beat.site_row), 32'(want.site_row));
                if (out_beat.site_col !== want.site_col)
                    report_mismatch("site_col", 32'(out_beat.site_col), 32'(want.site_col));
                if (out_beat.lower_value !== want.lower_value)
                    report_mismatch("lower_value", 32'(out_beat.lower_value),
                                    32'(want.lower_value));
                if (out_beat.upper_value !== want.upper_value)
                    report_mismatch("upper_value", 32'(out_beat.upper_value),
                                    32'(want.upper_value));
                if (out_beat.sweep_done !== want.sweep_done)
                    report_mismatch("sweep_done", 32'(out_beat.sweep_done),
                                    32'(want.sweep_done));
                if (out_beat.volume_gap !== want.volume_gap)
                    report_mismatch("volume_gap", 32'(out_beat.volume_gap),
                                    32'(want.volume_gap));
                if (out_beat.coalesced !== want.coalesced)
                    report_mismatch("coalesced", 32'(out_beat.coalesced),
                                    32'(want.coalesced));
            end
        end
    end

    // Receiver back-pressure: mostly ready, with short and occasional long stalls.
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
        end
    end

    task automatic test_default_order();
        send_beat(1'b1, 1'b0);
        send_beat(1'b0, 1'b1);
        send_beat(1'b0, 1'b0);
    endtask

    // Orders 0 and 1 have no interior; order 2 has a single site that ends every sweep
    // and coalesces at once.
    task automatic test_small_orders();
        write_order(6'd0);
        send_beat(1'b1, 1'b1);
        send_beat(1'b0, 1'b0);
        send_beat(1'b0, 1'b1);
        write_order(6'd1);
        send_beat(1'b1, 1'b1);
        send_beat(1'b0, 1'b1);
        write_order(6'd2);
        send_beat(1'b1, 1'b0);
        send_beat(1'b0, 1'b1);
        send_beat(1'b0, 1'b0);
        send_beat(1'b0, 1'b1);
    endtask

    task automatic test_largest_order();
        write_order(6'd63);
        send_beat(1'b1, 1'b0);
        send_beat(1'b0, 1'b1);
        send_beat(1'b0, 1'b0);
    endtask

    // Shrinking the order without a reload leaves the walk past the new interior;
    // four beats then cover one full sweep of the 2x2 interior.
    task automatic test_walk_relocation();
        write_order(6'd3);
        send_beat(1'b0, 1'b1);
        send_beat(1'b0, 1'b0);
        send_beat(1'b0, 1'b1);
        send_beat(1'b0, 1'b1);
    endtask

    task automatic test_random_walks();
        int               sent, burst, roll, i;
        logic [POS_W-1:0] next_order;
        sent = 0;
        while (sent < 480) begin
            roll = $urandom_range(0, 19);
            if (roll < 2) begin
                next_order = 6'($urandom_range(0, 1));
            end else if (roll < 14) begin
                next_order = 6'($urandom_range(2, 10));
            end else if (roll < 18) begin
                next_order = 6'($urandom_range(11, 62));
            end else begin
                next_order = 6'd63;
            end
            write_order(next_order);
            idle_on = ($urandom_range(0, 3) != 0);
            // A reload is required whenever the new grid reaches entries never written.
            if (int'(next_order) + 1 > loaded_side || $urandom_range(0, 3) != 0) begin
                send_beat(1'b1, 1'($urandom_range(0, 1)));
                sent++;
            end
            burst = $urandom_range(15, 60);
            for (i = 0; i < burst; i++) begin
                send_beat(1'($urandom_range(0, 49) == 0), 1'($urandom_range(0, 1)));
                sent++;
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_order();
        test_small_orders();
        test_largest_order();
        test_walk_relocation();
        test_random_walks();
        wait_idle();
        repeat (20) @(posedge clk);
        if (error_count == 0 && site_reports_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/asmh_pkg.sv
sv/asmh_grid.sv
sv/asmh_site_unit.sv
sv/asm_height_checkerboard_sampler_unit.sv
sim/tb_top.sv
